>>> src/incremental_pid_force_to_velocity_macros.svh
// Assertion macros for the incremental PID force-to-velocity block.
`ifndef INCREMENTAL_PID_FORCE_TO_VELOCITY_MACROS_SVH
`define INCREMENTAL_PID_FORCE_TO_VELOCITY_MACROS_SVH

// Same-cycle implication, checked on clk_i, off during reset.
`define IPTV_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("iptv: assertion failed");

// Next-cycle implication, checked on clk_i, off during reset.
`define IPTV_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("iptv: assertion failed");

`endif

>>> src/iptv_pkg.sv
// Shared types, constants and helper functions of the force-to-velocity PID.
`default_nettype none
package iptv_pkg;

  localparam int FRAC_BITS = 32;
  localparam int KP_FRAC   = 44;
  localparam int DT_FRAC   = 32;

  // Shift amounts of the gain and increment scaling.
  localparam int KA_SH     = FRAC_BITS + KP_FRAC - 39;
  localparam int KM_SH     = FRAC_BITS + KP_FRAC - 2 * DT_FRAC - 1;
  localparam int KM_MUL_SH = (KM_SH >= 0) ? KM_SH : 0;
  localparam int KM_DIV_SH = (KM_SH < 0) ? -KM_SH : 0;
  localparam int INC_SH    = KP_FRAC + 3;

  localparam logic [63:0] AUTO_DIVISOR = 64'd78125;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MASS       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CRUST      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_AMP_X      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_AMP_Y      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_AMP_Z      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_SPEED = 3'd6;

  localparam logic [31:0] TIME_STEP_RST = 32'd42950;

  localparam logic [49:0] MAG_MAX = 50'h2_0000_0000_0000;
  localparam logic [49:0] POS_LIM = 50'h0_7FFF_FFFF_FFFF;
  localparam logic [49:0] NEG_LIM = 50'h0_8000_0000_0000;

  typedef struct packed {
    logic signed [47:0] force_x;
    logic signed [47:0] force_y;
    logic signed [47:0] force_z;
  } in_t;

  typedef struct packed {
    logic signed [47:0] velocity_x;
    logic signed [47:0] velocity_y;
    logic signed [47:0] velocity_z;
    logic               gain_fault;
  } out_t;

  // Clamp an unsigned magnitude to 2^49.
  function automatic logic [49:0] mag_clamp(input logic [127:0] v);
    logic [49:0] r;
    if (v > {78'd0, MAG_MAX}) begin
      r = MAG_MAX;
    end else begin
      r = v[49:0];
    end
    return r;
  endfunction

  // Apply a sign to a magnitude and saturate to 48-bit signed.
  function automatic logic signed [47:0] sat_mag(input logic [49:0] m, input logic neg);
    logic signed [47:0] r;
    if (neg) begin
      if (m > NEG_LIM) begin
        r = 48'sh8000_0000_0000;
      end else begin
        r = -$signed(m[47:0]);
      end
    end else begin
      if (m > POS_LIM) begin
        r = 48'sh7FFF_FFFF_FFFF;
      end else begin
        r = $signed(m[47:0]);
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> src/incremental_pid_force_to_velocity.sv
// Top level: sequencer of the incremental PID that turns measured force into velocity.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_stall_o   in_data_i  (force x/y/z)
//   out      output     out_valid_o / out_stall_i out_data_o (velocity x/y/z, gain fault)
//   cfg      input      cfg_we_i                  cfg_index_i, cfg_data_i
//
// An item ends soonest on a fault, later before the first nonzero force and latest once
// the PID runs; the serial multiplier, divider and square root work one after the other.
// Reset clears the configuration to its defaults, the PID history and the force flag.
// in_stall_o is high from a transfer until the result is parked in the output
// register; a stalled output holds its result while the next item is taken.
`default_nettype none
`include "incremental_pid_force_to_velocity_macros.svh"
module incremental_pid_force_to_velocity import iptv_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire in_t                  in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output out_t                      out_data_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [47:0]          cfg_data_i
);

  // Sequencer states.
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_ISSUE = 4'd1;
  localparam logic [3:0] ST_MUL   = 4'd2;
  localparam logic [3:0] ST_DIV   = 4'd3;
  localparam logic [3:0] ST_RET   = 4'd4;
  localparam logic [3:0] ST_SQGO  = 4'd5;
  localparam logic [3:0] ST_SQRT  = 4'd6;
  localparam logic [3:0] ST_CHK   = 4'd7;
  localparam logic [3:0] ST_OUT   = 4'd8;

  // Operation being worked on.
  localparam logic [3:0] PH_SQ    = 4'd0;  // amplitude squares
  localparam logic [3:0] PH_DIR   = 4'd1;  // direction component
  localparam logic [3:0] PH_IDLEV = 4'd2;  // idle velocity
  localparam logic [3:0] PH_KA    = 4'd3;  // automatic gain, crust term
  localparam logic [3:0] PH_KA2   = 4'd4;  // automatic gain, divide by norm
  localparam logic [3:0] PH_KM0   = 4'd5;  // manual gain, dt squared
  localparam logic [3:0] PH_KM1   = 4'd6;  // manual gain, divide by mass
  localparam logic [3:0] PH_ERR   = 4'd7;  // projected error
  localparam logic [3:0] PH_INC   = 4'd8;  // displacement increment
  localparam logic [3:0] PH_VEL   = 4'd9;  // velocity from displacement

  localparam logic [1:0] AX_LAST = 2'd2;

  // configuration
  logic [31:0]        dt_q;
  logic [47:0]        mass_q;
  logic [31:0]        crust_q;
  logic signed [47:0] amp_q [3];
  logic [47:0]        idle_q;

  // control
  logic [3:0] state_q, state_d;
  logic [3:0] phase_q, phase_d;
  logic [1:0] ax_q, ax_d;
  logic       fs_q, fs_d;
  logic       out_valid_q, out_valid_d;

  // datapath
  logic signed [47:0] f_q [3];
  logic [97:0]        sum_q, sum_d;
  logic [63:0]        kp_q, kp_d;
  logic [49:0]        dmag_q [3];
  logic               dneg_q [3];
  logic signed [47:0] e_cur_q, e_cur_d;
  logic               s_neg_q, s_neg_d;
  logic signed [47:0] depl_q, depl_d;
  logic signed [47:0] ep_q [3];
  logic signed [47:0] epp_q [3];
  logic signed [47:0] ld_q [3];
  logic signed [47:0] vel_q [3];
  logic               fault_q, fault_d;
  out_t               out_q, out_d;

  // shared units
  logic         mul_go, mul_done;
  logic [63:0]  mul_a, mul_b;
  logic [127:0] prod;
  logic         div_go, div_done;
  logic [63:0]  div_c;
  logic [63:0]  quot;
  logic         sqrt_go, sqrt_done;
  logic [48:0]  root;

  // per-step strobes
  logic               accept;
  logic               dir_we, vel_we, vel_clr, pid_we, out_load;
  logic signed [47:0] vel_val;

  // helpers
  logic               autom;
  logic               ph_div;
  logic [47:0]        amp_abs;
  logic signed [48:0] diff;
  logic [48:0]        diff_abs;
  logic signed [53:0] e54, ep54, epp54, s;
  logic [53:0]        s_abs;
  logic [47:0]        depl_abs;
  logic [49:0]        m32, m47, mq;
  logic signed [50:0] inc;
  logic signed [51:0] dsum;
  logic signed [47:0] depl_sat;
  logic               d_pos;
  logic               fault;
  logic               vel_zero;

  assign accept = in_valid_i && !in_stall_o;
  assign autom  = (mass_q == 48'd0);

  iptv_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (mul_go),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .prod_o (prod)
  );

  iptv_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .go_i       (div_go),
    .dividend_i (prod),
    .divisor_i  (div_c),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  iptv_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (sqrt_go),
    .rad_i  (sum_q),
    .done_o (sqrt_done),
    .root_o (root)
  );

  // Operand shaping for the axis in work.
  always_comb begin
    amp_abs  = amp_q[ax_q][47] ? 48'(-amp_q[ax_q]) : 48'(amp_q[ax_q]);
    diff     = {f_q[ax_q][47], f_q[ax_q]} - {amp_q[ax_q][47], amp_q[ax_q]};
    diff_abs = diff[48] ? 49'(-diff) : 49'(diff);
    // s = 25 e - 10 e1 + e2, built from shifts
    e54      = {{6{e_cur_q[47]}}, e_cur_q};
    ep54     = {{6{ep_q[ax_q][47]}}, ep_q[ax_q]};
    epp54    = {{6{epp_q[ax_q][47]}}, epp_q[ax_q]};
    s        = (e54 <<< 4) + (e54 <<< 3) + e54 - (ep54 <<< 3) - (ep54 <<< 1) + epp54;
    s_abs    = s[53] ? 54'(-s) : 54'(s);
    depl_abs = depl_q[47] ? 48'(-depl_q) : 48'(depl_q);
    m32      = mag_clamp(prod >> FRAC_BITS);
    m47      = mag_clamp(prod >> INC_SH);
    mq       = mag_clamp({64'd0, quot});
    inc      = s_neg_q ? -$signed({1'b0, m47}) : $signed({1'b0, m47});
    dsum     = 52'(ld_q[ax_q]) + 52'(inc);
    if (dsum > 52'sh0_7FFF_FFFF_FFFF) begin
      depl_sat = 48'sh7FFF_FFFF_FFFF;
    end else if (dsum < -52'sh0_8000_0000_0000) begin
      depl_sat = 48'sh8000_0000_0000;
    end else begin
      depl_sat = dsum[47:0];
    end
    d_pos    = !dneg_q[ax_q] && (dmag_q[ax_q] != 50'd0);
    fault    = (root == 49'd0) || (dt_q == 32'd0) || (autom && (crust_q == 32'd0));
  end

  // Divisor and divide/shift choice by operation.
  always_comb begin
    ph_div = 1'b0;
    div_c  = 64'd0;
    case (phase_q)
      PH_DIR, PH_KA2: begin
        ph_div = 1'b1;
        div_c  = {15'd0, root};
      end
      PH_KA: begin
        ph_div = 1'b1;
        div_c  = AUTO_DIVISOR;
      end
      PH_KM1: begin
        ph_div = 1'b1;
        div_c  = {16'd0, mass_q} << KM_DIV_SH;
      end
      PH_VEL: begin
        ph_div = 1'b1;
        div_c  = {32'd0, dt_q};
      end
      default: begin
        ph_div = 1'b0;
        div_c  = 64'd0;
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_d  = state_q;
    phase_d  = phase_q;
    ax_d     = ax_q;
    sum_d    = sum_q;
    kp_d     = kp_q;
    e_cur_d  = e_cur_q;
    s_neg_d  = s_neg_q;
    depl_d   = depl_q;
    fault_d  = fault_q;
    mul_go   = 1'b0;
    mul_a    = 64'd0;
    mul_b    = 64'd0;
    div_go   = 1'b0;
    sqrt_go  = 1'b0;
    dir_we   = 1'b0;
    vel_we   = 1'b0;
    vel_clr  = 1'b0;
    pid_we   = 1'b0;
    out_load = 1'b0;
    vel_val  = '0;
    fs_d     = fs_q;
    if (accept && (in_data_i != '0)) begin
      fs_d = 1'b1;
    end
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          phase_d = PH_SQ;
          ax_d    = 2'd0;
          sum_d   = '0;
          state_d = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        mul_go  = 1'b1;
        state_d = ST_MUL;
        case (phase_q)
          PH_SQ: begin
            mul_a = {16'd0, amp_abs};
            mul_b = {16'd0, amp_abs};
          end
          PH_DIR: begin
            mul_a = {16'd0, amp_abs};
            mul_b = 64'd1 << FRAC_BITS;
          end
          PH_IDLEV: begin
            mul_a = {16'd0, idle_q};
            mul_b = {14'd0, dmag_q[ax_q]};
          end
          PH_KA: begin
            mul_a = {32'd0, crust_q};
            mul_b = 64'd1 << KA_SH;
          end
          PH_KA2: begin
            mul_a = kp_q;
            mul_b = 64'd1;
          end
          PH_KM0: begin
            mul_a = {32'd0, dt_q};
            mul_b = {32'd0, dt_q};
          end
          PH_KM1: begin
            mul_a = kp_q;
            mul_b = 64'd1 << KM_MUL_SH;
          end
          PH_ERR: begin
            mul_a = {15'd0, diff_abs};
            mul_b = {14'd0, dmag_q[ax_q]};
          end
          PH_INC: begin
            mul_a   = {10'd0, s_abs};
            mul_b   = kp_q;
            s_neg_d = s[53];
          end
          PH_VEL: begin
            mul_a = {16'd0, depl_abs};
            mul_b = 64'd1 << DT_FRAC;
          end
          default: begin
            mul_a = 64'd0;
            mul_b = 64'd0;
          end
        endcase
      end
      ST_MUL: begin
        if (mul_done) begin
          if (ph_div) begin
            div_go  = 1'b1;
            state_d = ST_DIV;
          end else begin
            state_d = ST_RET;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_RET;
        end
      end
      ST_RET: begin
        state_d = ST_ISSUE;
        case (phase_q)
          PH_SQ: begin
            sum_d = sum_q + prod[97:0];
            if (ax_q == AX_LAST) begin
              state_d = ST_SQGO;
            end else begin
              ax_d = ax_q + 2'd1;
            end
          end
          PH_DIR: begin
            dir_we = 1'b1;
            if (ax_q == AX_LAST) begin
              ax_d = 2'd0;
              if (!fs_q) begin
                phase_d = PH_IDLEV;
              end else if (autom) begin
                phase_d = PH_KA;
              end else begin
                phase_d = PH_KM0;
              end
            end else begin
              ax_d = ax_q + 2'd1;
            end
          end
          PH_IDLEV: begin
            // drive against the direction until a force shows up
            vel_we  = 1'b1;
            vel_val = sat_mag(m32, d_pos);
            if (ax_q == AX_LAST) begin
              state_d = ST_OUT;
            end else begin
              ax_d = ax_q + 2'd1;
            end
          end
          PH_KA: begin
            kp_d    = quot;
            phase_d = PH_KA2;
          end
          PH_KA2, PH_KM1: begin
            kp_d    = quot;
            phase_d = PH_ERR;
            ax_d    = 2'd0;
          end
          PH_KM0: begin
            kp_d    = prod[63:0];
            phase_d = PH_KM1;
          end
          PH_ERR: begin
            e_cur_d = sat_mag(m32, diff[48] ^ dneg_q[ax_q]);
            phase_d = PH_INC;
          end
          PH_INC: begin
            // advance the PID history of this axis
            depl_d  = depl_sat;
            pid_we  = 1'b1;
            phase_d = PH_VEL;
          end
          PH_VEL: begin
            vel_we  = 1'b1;
            vel_val = sat_mag(mq, depl_q[47]);
            if (ax_q == AX_LAST) begin
              state_d = ST_OUT;
            end else begin
              ax_d    = ax_q + 2'd1;
              phase_d = PH_ERR;
            end
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end
      ST_SQGO: begin
        sqrt_go = 1'b1;
        state_d = ST_SQRT;
      end
      ST_SQRT: begin
        if (sqrt_done) begin
          state_d = ST_CHK;
        end
      end
      ST_CHK: begin
        if (fault) begin
          // zero divisor or zero crust gain: report zero velocity and hold the PID state
          vel_clr = 1'b1;
          fault_d = 1'b1;
          state_d = ST_OUT;
        end else begin
          fault_d = 1'b0;
          phase_d = PH_DIR;
          ax_d    = 2'd0;
          state_d = ST_ISSUE;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_d.velocity_x = vel_q[0];
    out_d.velocity_y = vel_q[1];
    out_d.velocity_z = vel_q[2];
    out_d.gain_fault = fault_q;
    out_valid_d      = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  // Control and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_SQ;
      ax_q        <= 2'd0;
      fs_q        <= 1'b0;
      out_valid_q <= 1'b0;
      dt_q        <= TIME_STEP_RST;
      mass_q      <= '0;
      crust_q     <= '0;
      idle_q      <= '0;
      for (int i = 0; i < 3; i++) begin
        amp_q[i] <= '0;
        ep_q[i]  <= '0;
        epp_q[i] <= '0;
        ld_q[i]  <= '0;
      end
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      ax_q        <= ax_d;
      fs_q        <= fs_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_TIME_STEP:  dt_q     <= cfg_data_i[31:0];
          CFG_MASS:       mass_q   <= cfg_data_i;
          CFG_CRUST:      crust_q  <= cfg_data_i[31:0];
          CFG_AMP_X:      amp_q[0] <= cfg_data_i;
          CFG_AMP_Y:      amp_q[1] <= cfg_data_i;
          CFG_AMP_Z:      amp_q[2] <= cfg_data_i;
          CFG_IDLE_SPEED: idle_q   <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (pid_we) begin
        epp_q[ax_q] <= ep_q[ax_q];
        ep_q[ax_q]  <= e_cur_q;
        ld_q[ax_q]  <= depl_sat;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    sum_q   <= sum_d;
    kp_q    <= kp_d;
    e_cur_q <= e_cur_d;
    s_neg_q <= s_neg_d;
    depl_q  <= depl_d;
    fault_q <= fault_d;
    if (accept) begin
      f_q[0] <= in_data_i.force_x;
      f_q[1] <= in_data_i.force_y;
      f_q[2] <= in_data_i.force_z;
    end
    if (dir_we) begin
      dmag_q[ax_q] <= mq;
      dneg_q[ax_q] <= amp_q[ax_q][47];
    end
    if (vel_clr) begin
      for (int i = 0; i < 3; i++) begin
        vel_q[i] <= '0;
      end
    end else if (vel_we) begin
      vel_q[ax_q] <= vel_val;
    end
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign vel_zero = (out_q.velocity_x == '0) && (out_q.velocity_y == '0) &&
                    (out_q.velocity_z == '0);

  `IPTV_ASSERT_NXT(a_stall_after_transfer, accept, in_stall_o)
  `IPTV_ASSERT_IMP(a_fault_zero_vel, out_valid_o && out_data_o.gain_fault, vel_zero)
  `IPTV_ASSERT_IMP(a_mul_done_in_mul, mul_done, state_q == ST_MUL)
  `IPTV_ASSERT_IMP(a_div_done_in_div, div_done, state_q == ST_DIV)

endmodule
`default_nettype wire

>>> src/iptv_mul.sv
// Bit-serial 64x64 unsigned multiplier, one multiplier bit per cycle.
`default_nettype none
module iptv_mul import iptv_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         go_i,
  input  wire logic [63:0]  a_i,
  input  wire logic [63:0]  b_i,
  output logic              done_o,
  output logic [127:0]      prod_o
);

  logic [127:0] acc_q, acc_d;
  logic [63:0]  mcand_q, mcand_d;
  logic [63:0]  mplier_q, mplier_d;
  logic [5:0]   cnt_q, cnt_d;
  logic         busy_q, busy_d;
  logic         done_q, done_d;
  logic [64:0]  sum;

  always_comb begin
    sum      = {1'b0, acc_q[127:64]} + (mplier_q[0] ? {1'b0, mcand_q} : 65'd0);
    acc_d    = acc_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    cnt_d    = cnt_q;
    busy_d   = busy_q;
    done_d   = 1'b0;
    if (go_i) begin
      acc_d    = '0;
      mcand_d  = a_i;
      mplier_d = b_i;
      cnt_d    = '0;
      busy_d   = 1'b1;
    end else if (busy_q) begin
      // add into the top half, then shift the whole accumulator right
      acc_d    = {sum, acc_q[63:1]};
      mplier_d = {1'b0, mplier_q[63:1]};
      cnt_d    = cnt_q + 6'd1;
      if (cnt_q == 6'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule
`default_nettype wire

>>> src/iptv_div.sv
// Restoring 128/64 unsigned divider, one quotient bit per cycle, saturating.
`default_nettype none
module iptv_div import iptv_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         go_i,
  input  wire logic [127:0] dividend_i,
  input  wire logic [63:0]  divisor_i,
  output logic              done_o,
  output logic [63:0]       quot_o
);

  logic [63:0] rem_q, rem_d;
  logic [63:0] ql_q, ql_d;
  logic [63:0] c_q, c_d;
  logic        sat_q, sat_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [64:0] trial;
  logic [64:0] diff;
  logic        ge;

  always_comb begin
    trial  = {rem_q, ql_q[63]};
    diff   = trial - {1'b0, c_q};
    ge     = (trial >= {1'b0, c_q});
    rem_d  = rem_q;
    ql_d   = ql_q;
    c_d    = c_q;
    sat_d  = sat_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (go_i) begin
      rem_d = dividend_i[127:64];
      ql_d  = dividend_i[63:0];
      c_d   = divisor_i;
      cnt_d = '0;
      // quotient would not fit in 64 bits: saturate and finish at once
      if ((divisor_i == 64'd0) || (dividend_i[127:64] >= divisor_i)) begin
        sat_d  = 1'b1;
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        sat_d  = 1'b0;
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      rem_d = ge ? diff[63:0] : trial[63:0];
      ql_d  = {ql_q[62:0], ge};
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    ql_q  <= ql_d;
    c_q   <= c_d;
    sat_q <= sat_d;
  end

  assign done_o = done_q;
  assign quot_o = sat_q ? '1 : ql_q;

endmodule
`default_nettype wire

>>> src/iptv_sqrt.sv
// Digit-serial integer square root, two radicand bits per cycle.
`default_nettype none
module iptv_sqrt import iptv_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        go_i,
  input  wire logic [97:0] rad_i,
  output logic             done_o,
  output logic [48:0]      root_o
);

  logic [97:0] rad_q, rad_d;
  logic [49:0] rem_q, rem_d;
  logic [48:0] root_q, root_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [51:0] cur;
  logic [51:0] trial;
  logic [51:0] diff;
  logic        ge;

  always_comb begin
    cur    = {rem_q, rad_q[97:96]};
    trial  = {1'b0, root_q, 2'b01};
    diff   = cur - trial;
    ge     = (cur >= trial);
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (go_i) begin
      rad_d  = rad_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d  = {rad_q[95:0], 2'b00};
      rem_d  = ge ? diff[49:0] : cur[49:0];
      root_d = {root_q[47:0], ge};
      cnt_d  = cnt_q + 6'd1;
      if (cnt_q == 6'd48) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule
`default_nettype wire

>>> tb/sv/incremental_pid_force_to_velocity_test.sv
// Self-checking testbench of the incremental PID force-to-velocity block.
`timescale 1ns / 1ps
module incremental_pid_force_to_velocity_test;
  import iptv_pkg::*;

  localparam longint CYCLE_LIMIT = 64'd12_000_000;
  localparam longint POS48 = 64'sh7FFF_FFFF_FFFF;
  localparam longint NEG48 = -64'sh8000_0000_0000;
  // Index just past the register list; the block must ignore writes to it.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [47:0] cfg_data_i = '0;

  incremental_pid_force_to_velocity u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o, .cfg_we_i, .cfg_index_i, .cfg_data_i
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Shadow copy of the block's registers and PID history.
  logic [31:0] dt_q;
  logic [47:0] mass_q, idle_q;
  logic [31:0] crust_q;
  logic signed [47:0] amp_q [3];
  longint err1_q [3], err2_q [3], depl_q [3];
  logic seen_q;

  in_t  force_queue [$];
  out_t velocity_queue [$];
  int   mismatches = 0;
  int   transfers_in = 0, transfers_out = 0, faults_seen = 0, phases = 0;
  logic calm = 1'b0;   // no idling on either side in the closing stretch
  longint cycles = 0;

  function automatic logic [63:0] magn(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  // Apply a sign to a magnitude clamped to 2^49.
  function automatic longint with_sign(logic [63:0] m, logic neg);
    logic [63:0] c;
    c = (m > (64'd1 << 49)) ? (64'd1 << 49) : m;
    return neg ? -$signed(c) : $signed(c);
  endfunction

  function automatic longint sat48(longint v);
    return (v > POS48) ? POS48 : ((v < NEG48) ? NEG48 : v);
  endfunction

  // floor(a*b/c), saturating at all ones; a zero divisor saturates too.
  function automatic logic [63:0] muldiv(logic [63:0] a, logic [63:0] b, logic [63:0] c);
    logic [127:0] q;
    if (c == 0) return '1;
    q = ({64'd0, a} * {64'd0, b}) / {64'd0, c};
    if (q[127:64] != 0) return '1;
    return q[63:0];
  endfunction

  function automatic logic [63:0] isqrt(logic [127:0] s);
    logic [63:0] r, c;
    r = 0;
    for (int b = 48; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if ({64'd0, c} * {64'd0, c} <= s) r = c;
    end
    return r;
  endfunction

  // Advance the shadow PID by one force sample and return the velocity command.
  function automatic out_t predict_velocity(in_t it);
    longint f [3], a [3], d [3], v [3];
    longint diff, e, s, inc, depl;
    logic [127:0] sq;
    logic [63:0] n, kp;
    logic autom;
    out_t r;
    f[0] = it.force_x; f[1] = it.force_y; f[2] = it.force_z;
    sq = 0;
    for (int i = 0; i < 3; i++) begin
      a[i] = amp_q[i];
      if (f[i] != 0) seen_q = 1'b1;
      sq += {64'd0, magn(a[i])} * {64'd0, magn(a[i])};
    end
    n = isqrt(sq);
    autom = (mass_q == 0);
    r = '0;
    if (n == 0 || dt_q == 0 || (autom && crust_q == 0)) begin
      r.gain_fault = 1'b1;
      return r;
    end
    for (int i = 0; i < 3; i++)
      d[i] = with_sign(muldiv(magn(a[i]), 64'd1 << FRAC_BITS, n), a[i] < 0);
    if (!seen_q) begin
      // drift toward the obstacle until contact is felt
      for (int i = 0; i < 3; i++)
        v[i] = sat48(with_sign(muldiv({16'd0, idle_q}, magn(d[i]), 64'd1 << FRAC_BITS),
                               d[i] > 0));
    end else begin
      if (autom)
        kp = muldiv({32'd0, crust_q}, 64'd1 << 37, 64'd78125) / n;
      else
        kp = muldiv({32'd0, dt_q} * {32'd0, dt_q}, 64'd1 << 11, {16'd0, mass_q});
      for (int i = 0; i < 3; i++) begin
        diff = f[i] - a[i];
        e = sat48(with_sign(muldiv(magn(diff), magn(d[i]), 64'd1 << FRAC_BITS),
                            (diff < 0) != (d[i] < 0)));
        s = 25 * e - 10 * err1_q[i] + err2_q[i];
        inc = with_sign(muldiv(magn(s), kp, 64'd1 << 47), s < 0);
        depl = sat48(depl_q[i] + inc);
        v[i] = sat48(with_sign(muldiv(magn(depl), 64'd1 << 32, {32'd0, dt_q}), depl < 0));
        err2_q[i] = err1_q[i];
        err1_q[i] = e;
        depl_q[i] = depl;
      end
    end
    r.velocity_x = v[0][47:0];
    r.velocity_y = v[1][47:0];
    r.velocity_z = v[2][47:0];
    return r;
  endfunction

  // Driver: present queued force samples, with random gaps between transfers.
  int gap_cnt = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        velocity_queue.push_back(predict_velocity(in_data_i));
        transfers_in++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_cnt > 0) begin
          gap_cnt--;
          in_valid_i <= 1'b0;
        end else if (force_queue.size() > 0) begin
          in_data_i <= force_queue.pop_front();
          in_valid_i <= 1'b1;
          if (!calm && $urandom_range(0, 3) == 0) gap_cnt = $urandom_range(1, 19);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: stall the result side in bursts and check every transfer.
  int stall_cnt = 0;
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        transfers_out++;
        if (out_data_o.gain_fault) faults_seen++;
        if (velocity_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", out_data_o);
        end else begin
          want = velocity_queue.pop_front();
          if (out_data_o.velocity_x !== want.velocity_x ||
              out_data_o.velocity_y !== want.velocity_y ||
              out_data_o.velocity_z !== want.velocity_z ||
              out_data_o.gain_fault !== want.gain_fault) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d: expected v=(%h %h %h) fault=%b, got v=(%h %h %h) fault=%b",
                       transfers_out, want.velocity_x, want.velocity_y, want.velocity_z,
                       want.gain_fault, out_data_o.velocity_x, out_data_o.velocity_y,
                       out_data_o.velocity_z, out_data_o.gain_fault);
          end
        end
      end
      if (stall_cnt > 0) begin
        stall_cnt--;
        out_stall_i <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_cnt = $urandom_range(0, 18);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               velocity_queue.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Write one register and mirror it in the shadow copy.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [47:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    case (idx)
      CFG_TIME_STEP:  dt_q = value[31:0];
      CFG_MASS:       mass_q = value;
      CFG_CRUST:      crust_q = value[31:0];
      CFG_AMP_X:      amp_q[0] = value;
      CFG_AMP_Y:      amp_q[1] = value;
      CFG_AMP_Z:      amp_q[2] = value;
      CFG_IDLE_SPEED: idle_q = value;
      default: ;
    endcase
  endtask

  task automatic setup(logic [31:0] dt, logic [47:0] mass, logic [31:0] crust,
                       logic [47:0] ax, logic [47:0] ay, logic [47:0] az, logic [47:0] idle);
    write_reg(CFG_TIME_STEP, {16'd0, dt});
    write_reg(CFG_MASS, mass);
    write_reg(CFG_CRUST, {16'd0, crust});
    write_reg(CFG_AMP_X, ax);
    write_reg(CFG_AMP_Y, ay);
    write_reg(CFG_AMP_Z, az);
    write_reg(CFG_IDLE_SPEED, idle);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    phases++;
  endtask

  // Hold the sender until every queued sample has produced its result.
  task automatic drain();
    while (force_queue.size() != 0 || in_valid_i || velocity_queue.size() != 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // Random 48-bit value of random magnitude and sign.
  function automatic logic [47:0] rnd48();
    logic [47:0] v;
    v = 48'({$urandom, $urandom} >> $urandom_range(0, 47));
    if ($urandom_range(0, 3) == 0) v = 48'({$urandom, $urandom});
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  task automatic push_force(logic [47:0] x, logic [47:0] y, logic [47:0] z);
    in_t it;
    it.force_x = x; it.force_y = y; it.force_z = z;
    force_queue.push_back(it);
  endtask

  initial begin
    logic [47:0] ax, ay, az;
    logic [31:0] dt;
    dt_q = TIME_STEP_RST; mass_q = 0; crust_q = 0; idle_q = 0; seen_q = 1'b0;
    for (int i = 0; i < 3; i++) begin
      amp_q[i] = 0; err1_q[i] = 0; err2_q[i] = 0; depl_q[i] = 0;
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Defaults: zero amplitude norm faults every step.
    repeat (2) push_force('0, '0, '0);
    drain();

    // Idle drift before any contact, then the first contact and extremes.
    setup(32'hFFFF_FFFF, '0, 32'hFFFF_FFFF, 48'h1_0000_0000, -48'h2_0000_0000,
          48'h3_0000_0000, 48'hFFFF_FFFF_FFFF);
    write_reg(CFG_UNUSED, '1);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    repeat (3) push_force('0, '0, '0);
    drain();
    setup(32'd42950, '0, 32'd1000, 48'h0_0000_0001, '0, '0, 48'h1_0000_0000);
    push_force('0, '0, '0);
    drain();
    setup(32'd1, 48'd1, '0, 48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF,
          48'd5);
    push_force(48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 48'd1);
    push_force(48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    push_force(48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF);
    push_force('0, '0, '0);
    drain();
    setup(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, '0, 48'h8000_0000_0000, '0, 48'd3, '0);
    push_force(48'h1234_5678_9ABC, -48'd7, 48'h0F0F_0F0F_0F0F);
    push_force(48'h8000_0000_0000, '0, 48'd3);
    drain();
    // Zero time step faults, and so does automatic mass with zero crust.
    setup('0, 48'h1_0000_0000, 32'd5, 48'h1_0000_0000, '0, '0, '0);
    push_force(48'd1, '0, '0);
    drain();
    setup(32'd42950, '0, '0, 48'h1_0000_0000, 48'h1_0000_0000, '0, '0);
    push_force(48'd1, 48'd2, 48'd3);
    drain();

    // Random settings, each followed by a batch of random force samples.
    for (int p = 0; p < 14; p++) begin
      if (p == 13) calm = 1'b1;
      case ($urandom_range(0, 3))
        0: dt = 32'hFFFF_FFFF;
        1: dt = 32'd1 + $urandom_range(0, 100);
        default: dt = $urandom >> $urandom_range(0, 31);
      endcase
      ax = rnd48(); ay = rnd48(); az = rnd48();
      if ($urandom_range(0, 9) == 0) begin ax = '0; ay = '0; az = '0; end
      setup(dt, $urandom_range(0, 1) ? '0 : rnd48() & 48'h7FFF_FFFF_FFFF | 48'd1,
            $urandom_range(0, 9) == 0 ? 32'd0 : $urandom >> $urandom_range(0, 31),
            ax, ay, az, rnd48());
      for (int k = 0; k < 48; k++) begin
        case ($urandom_range(0, 5))
          0: push_force(ax, ay, az);
          1: push_force(ax + rnd48() >> 16, ay - ($urandom & 16'hFFFF), az);
          2: push_force(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                        48'({$urandom, $urandom}));
          default: push_force(rnd48(), rnd48(), rnd48());
        endcase
      end
      drain();
    end

    $display("%0d force samples over %0d register settings, %0d velocity results",
             transfers_in, phases, transfers_out);
    $display("%0d results flagged a gain fault, %0d mismatches", faults_seen, mismatches);
    if (mismatches == 0 && velocity_queue.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> incremental_pid_force_to_velocity.f
+incdir+src
src/iptv_pkg.sv
src/iptv_mul.sv
src/iptv_div.sv
src/iptv_sqrt.sv
src/incremental_pid_force_to_velocity.sv
tb/sv/incremental_pid_force_to_velocity_test.sv
